### rtl/gpsg_pkg.sv
// Package for the geometric prime size generator.
// Holds the shared widths, constants, sequencer states and the remainder unit status type.
// No dependencies.
`timescale 1ns / 1ps

package gpsg_pkg;

    // Field and table geometry
    localparam int VALUE_W     = 28;
    localparam int THR_W       = VALUE_W + 1;           // next threshold may pass 2^VALUE_W
    localparam int STORE_DEPTH = 2048;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int PRIME_W     = 16;
    localparam int SQ_OP_W     = PRIME_W + 1;           // room for last prime + 1
    localparam int SQ_W        = 2 * SQ_OP_W;
    localparam int BIT_CNT_W   = $clog2(VALUE_W);

    // Sequence constants
    localparam logic [THR_W-1:0]   FIRST_THRESHOLD = THR_W'(32);
    localparam logic [VALUE_W-1:0] FIRST_PRIME     = VALUE_W'(2);
    localparam logic [VALUE_W-1:0] LIMIT_RESET     = VALUE_W'(100000000);

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_LOOP,
        S_RD,
        S_SQ,
        S_CMP,
        S_DIV,
        S_TAIL,
        S_TCMP,
        S_FOUND,
        S_EMIT
    } t_state;

    // Remainder unit status back to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_rem_status;

endpackage

### rtl/gpsg_rem_unit.sv
// Iterative remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on gpsg_pkg for widths and the status struct.
`timescale 1ns / 1ps

module gpsg_rem_unit import gpsg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [VALUE_W-1:0]   i_dividend,
    input  logic [PRIME_W-1:0]   i_divisor,
    output t_rem_status          o_status
);

    logic                 r_busy;
    logic                 r_done;
    logic [BIT_CNT_W-1:0] r_bit;
    logic [PRIME_W-1:0]   r_rem;
    logic [VALUE_W-1:0]   r_dvd;
    logic [PRIME_W-1:0]   r_dsr;

    logic [PRIME_W:0]     trial;
    logic [PRIME_W-1:0]   n_rem;

    // Restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[VALUE_W-1]};
        if (trial >= {1'b0, r_dsr}) begin
            n_rem = PRIME_W'(trial - {1'b0, r_dsr});
        end else begin
            n_rem = trial[PRIME_W-1:0];
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bit <= BIT_CNT_W'(VALUE_W - 1);
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_bit <= r_bit - 1'b1;
            r_rem <= n_rem;
            r_dvd <= {r_dvd[VALUE_W-2:0], 1'b0};
        end
    end

    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule

### rtl/geometric_prime_size_generator.sv
// Top level of the geometric prime size generator: sequencer, prime table, shared squarer.
// Depends on gpsg_pkg and gpsg_rem_unit.
//
// Usage:
//  - Request channel (i_s_axis_*): one item per size wanted; tdata bit 0 = restart.
//    restart = 1 starts over at threshold 32 with the table holding only 2.
//  - Result channel (o_m_axis_*): one item per request. tdata holds prime_size
//    (bits 27:0) and threshold (bits 55:28); tlast marks the final size of the
//    sequence; tuser set means nothing is left (tdata then is zero).
//  - Config channel (i_cfg_*): size limit, always ready; write only while idle.
//  - Requests: one in flight. A request tests trial divisors for each candidate;
//    each trial divisor costs a table read, a square on the shared multiplier
//    and a bit-serial remainder (28 steps). The work grows with the threshold,
//    since each size searches about a quarter of it.
//  - Hand-off: the result register loads when the search ends; a new request is
//    accepted in the cycle after, even while that result waits.
//  - Reset clears the sequence state (threshold 32, one prime stored) and sets
//    the limit to 100000000; table entry 0 is a constant, so no clearing pass.
//  - A stalled receiver holds the result; a finished next search waits for it.
`timescale 1ns / 1ps

module geometric_prime_size_generator import gpsg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [7:0]          i_s_axis_tdata,   // [0] restart
    // result channel
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [55:0]         o_m_axis_tdata,   // [27:0] prime_size, [55:28] threshold
    output logic                o_m_axis_tlast,   // is_last
    output logic                o_m_axis_tuser,   // [0] none_left
    // config channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [VALUE_W-1:0]  i_cfg_data        // size_limit
);

    t_state r_state, n_state;

    // Sequence state
    logic [CNT_W-1:0]   r_count,    n_count;
    logic [VALUE_W-1:0] r_cand,     n_cand;
    logic [THR_W-1:0]   r_next_thr, n_next_thr;
    logic [VALUE_W-1:0] r_largest,  n_largest;
    logic               r_finished, n_finished;
    logic [VALUE_W-1:0] r_limit;

    // Trial division working registers
    logic [CNT_W-1:0]   r_idx,      n_idx;
    logic [PRIME_W-1:0] r_p,        n_p;
    logic [PRIME_W-1:0] r_last,     n_last;
    logic [SQ_W-1:0]    r_sq,       n_sq;
    logic               r_rd_zero,  n_rd_zero;

    // Pending result
    logic [VALUE_W-1:0] r_pend_prime, n_pend_prime;
    logic [VALUE_W-1:0] r_pend_thr,   n_pend_thr;
    logic               r_pend_last,  n_pend_last;
    logic               r_pend_none,  n_pend_none;

    // Output register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_prime;
    logic [VALUE_W-1:0] r_out_thr;
    logic               r_out_last;
    logic               r_out_none;

    // Prime table
    logic [PRIME_W-1:0] mem [STORE_DEPTH];
    logic [PRIME_W-1:0] r_mem_q;
    logic               mem_we;

    logic               in_accept;
    logic               out_load;
    logic               rem_start;
    t_rem_status        rem_status;
    logic [SQ_OP_W-1:0] mul_a;
    logic [SQ_W-1:0]    mul_p;
    logic [PRIME_W-1:0] p_now;
    logic [THR_W-1:0]   thr_step;
    logic               table_full;

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign table_full      = (r_count >= CNT_W'(STORE_DEPTH));
    assign p_now           = r_rd_zero ? PRIME_W'(FIRST_PRIME) : r_mem_q;
    assign thr_step        = r_next_thr + (r_next_thr >> 2);

    // Shared squarer: candidate divisor, or last stored prime + 1 at the table end
    assign mul_a = (r_state == S_TAIL) ? (SQ_OP_W'(r_last) + 1'b1) : {1'b0, p_now};
    assign mul_p = {{SQ_OP_W{1'b0}}, mul_a} * {{SQ_OP_W{1'b0}}, mul_a};

    gpsg_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_cand),
        .i_divisor  (r_p),
        .o_status   (rem_status)
    );

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cand       = r_cand;
        n_next_thr   = r_next_thr;
        n_largest    = r_largest;
        n_finished   = r_finished;
        n_idx        = r_idx;
        n_p          = r_p;
        n_last       = r_last;
        n_sq         = r_sq;
        n_rd_zero    = r_rd_zero;
        n_pend_prime = r_pend_prime;
        n_pend_thr   = r_pend_thr;
        n_pend_last  = r_pend_last;
        n_pend_none  = r_pend_none;
        mem_we       = 1'b0;
        rem_start    = 1'b0;
        out_load     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_s_axis_tdata[0]) begin
                        n_count    = CNT_W'(1);
                        n_cand     = FIRST_PRIME;
                        n_next_thr = FIRST_THRESHOLD;
                        n_largest  = FIRST_PRIME;
                        n_finished = 1'b0;
                    end
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_finished || r_next_thr >= {1'b0, r_limit}) begin
                    n_pend_prime = '0;
                    n_pend_thr   = '0;
                    n_pend_last  = 1'b0;
                    n_pend_none  = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if ({1'b0, r_cand} >= r_next_thr) begin
                    // threshold reached: report the largest prime so far
                    n_next_thr   = thr_step;
                    n_pend_prime = r_largest;
                    n_pend_thr   = r_next_thr[VALUE_W-1:0];
                    n_pend_last  = (thr_step >= {1'b0, r_limit});
                    n_pend_none  = 1'b0;
                    if (thr_step >= {1'b0, r_limit}) begin
                        n_finished = 1'b1;
                    end
                    n_state = S_EMIT;
                end else begin
                    n_cand  = r_cand + 1'b1;
                    n_idx   = '0;
                    n_last  = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_idx < r_count) begin
                    n_rd_zero = (r_idx == '0);
                    n_state   = S_SQ;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_SQ: begin
                n_p     = p_now;
                n_sq    = mul_p;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_sq > SQ_W'(r_cand)) begin
                    n_state = S_FOUND;
                end else if (r_p != '0) begin
                    rem_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_last  = r_p;
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_DIV: begin
                if (rem_status.done) begin
                    if (rem_status.rem_zero) begin
                        n_state = S_LOOP;
                    end else begin
                        n_last  = r_p;
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_TAIL: begin
                n_sq    = mul_p;
                n_state = S_TCMP;
            end
            S_TCMP: begin
                if (table_full && r_sq <= SQ_W'(r_cand)) begin
                    // table no longer covers the square root: sequence ends
                    n_finished   = 1'b1;
                    n_pend_prime = '0;
                    n_pend_thr   = '0;
                    n_pend_last  = 1'b0;
                    n_pend_none  = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_FOUND;
                end
            end
            S_FOUND: begin
                n_largest = r_cand;
                if (!table_full) begin
                    mem_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end
                n_state = S_LOOP;
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(1);
            r_cand      <= FIRST_PRIME;
            r_next_thr  <= FIRST_THRESHOLD;
            r_largest   <= FIRST_PRIME;
            r_finished  <= 1'b0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_cand     <= n_cand;
            r_next_thr <= n_next_thr;
            r_largest  <= n_largest;
            r_finished <= n_finished;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_p          <= n_p;
        r_last       <= n_last;
        r_sq         <= n_sq;
        r_rd_zero    <= n_rd_zero;
        r_pend_prime <= n_pend_prime;
        r_pend_thr   <= n_pend_thr;
        r_pend_last  <= n_pend_last;
        r_pend_none  <= n_pend_none;
        if (out_load) begin
            r_out_prime <= r_pend_prime;
            r_out_thr   <= r_pend_thr;
            r_out_last  <= r_pend_last;
            r_out_none  <= r_pend_none;
        end
    end

    // Prime table: entry 0 is the constant 2 and its array word is never used
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[STORE_AW-1:0]] <= r_cand[PRIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_mem_q <= mem[r_idx[STORE_AW-1:0]];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_thr, r_out_prime};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_none;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_s_axis_tready)
        else $error("request taken while a search was running");

    a_cand_below_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cand} <= r_next_thr)
        else $error("candidate ran past the threshold");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CNT_W'(STORE_DEPTH)))
        else $error("prime count out of range");

    a_rem_nonzero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_start |-> (r_p != '0) && (r_state == S_CMP))
        else $error("remainder started with a zero divisor");

    a_none_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0) && !o_m_axis_tlast)
        else $error("empty result carries data");

endmodule
